// ===== rtl/core/pca_pkg.sv =====
package pca_pkg;

    // Block configuration
    localparam int CPUS       = 8;
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;

    // Derived widths
    localparam int ADDR_W     = 32;
    localparam int CPU_IN_W   = 3;
    localparam int CPU_W      = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'h8800_0000;

    typedef logic [CPU_W-1:0] cpu_t;
    typedef logic [IDX_W-1:0] page_idx_t;

    // One list link or head: empty marks the end of a list.
    typedef struct packed {
        logic      empty;
        page_idx_t idx;
    } link_t;

    localparam link_t LINK_NULL = '{empty: 1'b1, idx: '0};

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] alloc_address;
    } result_t;

    // Link memory access for one cycle
    typedef struct packed {
        logic      rd_en;
        page_idx_t rd_addr;
        logic      wr_en;
        page_idx_t wr_addr;
        link_t     wr_data;
    } link_req_t;

    // Fold a requester number onto the CPU count.
    function automatic cpu_t cpu_wrap(logic [CPU_IN_W-1:0] raw);
        logic [CPU_IN_W-1:0] v;
        v = raw;
        if (CPUS < (1 << CPU_IN_W)) begin
            for (int i = 0; i < (1 << CPU_IN_W); i++) begin
                if (int'(v) >= CPUS) begin
                    v = v - CPU_IN_W'(CPUS);
                end
            end
        end
        return CPU_W'(v);
    endfunction

endpackage

// ===== rtl/core/pca_link_ram.sv =====
module pca_link_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pca_ctrl.sv =====
module pca_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_func,
    input  pca_pkg::cpu_t              in_cpu,
    input  logic [pca_pkg::ADDR_W-1:0] in_addr,
    input  pca_pkg::cfg_t              cfg,
    output logic                       res_valid,
    output pca_pkg::result_t           res,
    input  logic                       res_ready,
    output pca_pkg::link_req_t         link_req,
    input  pca_pkg::link_t             link_rd_data
);
    import pca_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_LOAD,
        ST_STEAL_RD,
        ST_STEAL_WB,
        ST_POP_RD,
        ST_POP_WB,
        ST_RESP
    } state_t;

    localparam logic [ADDR_W-1:0] OFFS_MASK = ADDR_W'(PAGE_BYTES - 1);

    state_t            state_reg;
    link_t             head_reg [CPUS];
    logic              func_reg;
    cpu_t              cpu_reg;
    logic [ADDR_W-1:0] addr_reg;
    cpu_t              steal_reg;
    link_t             own_reg;
    page_idx_t         victim_reg;
    result_t           res_reg;

    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W:0]   page_ext;
    logic              bad_addr;
    page_idx_t         free_idx;
    cpu_t              head_sel;
    link_t             head_rd;
    logic              steal_last;
    logic              steal_take;
    logic [ADDR_W-1:0] pop_addr;

    always_comb begin
        base       = cfg.region_start & ~OFFS_MASK;
        offset     = addr_reg - base;
        page_ext   = (ADDR_W+1)'(offset >> PAGE_SHIFT);
        bad_addr   = ((addr_reg & OFFS_MASK) != '0) || (addr_reg < cfg.region_start)
                     || (addr_reg >= cfg.region_end)
                     || (page_ext >= (ADDR_W+1)'(NUM_PAGES));
        free_idx   = page_ext[IDX_W-1:0];
        // One head read and one head write port, both steered here
        head_sel   = (state_reg == ST_STEAL_RD || state_reg == ST_STEAL_WB) ? steal_reg
                                                                            : cpu_reg;
        head_rd    = head_reg[head_sel];
        steal_last = (steal_reg == CPU_W'(CPUS - 1));
        steal_take = (steal_reg != cpu_reg) && !head_rd.empty;
        pop_addr   = base + (ADDR_W'(own_reg.idx) << PAGE_SHIFT);
    end

    always_comb begin
        link_req = '0;
        unique case (state_reg)
            ST_FREE: begin
                if (!bad_addr) begin
                    link_req.wr_en   = 1'b1;
                    link_req.wr_addr = free_idx;
                    link_req.wr_data = head_rd;
                end
            end
            ST_STEAL_RD: begin
                if (steal_take) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = head_rd.idx;
                end
            end
            ST_STEAL_WB: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = victim_reg;
                link_req.wr_data = own_reg;
            end
            ST_POP_RD: begin
                if (!own_reg.empty) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = own_reg.idx;
                end
            end
            ST_IDLE, ST_LOAD, ST_POP_WB, ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < CPUS; i++) begin
                head_reg[i] <= LINK_NULL;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        func_reg  <= in_func;
                        cpu_reg   <= in_cpu;
                        addr_reg  <= in_addr;
                        state_reg <= in_func ? ST_FREE : ST_LOAD;
                    end
                end
                ST_FREE: begin
                    if (!bad_addr) begin
                        head_reg[head_sel] <= '{empty: 1'b0, idx: free_idx};
                    end
                    res_reg.status        <= bad_addr ? STATUS_BAD_ADDR : STATUS_OK;
                    res_reg.alloc_address <= '0;
                    state_reg             <= ST_RESP;
                end
                ST_LOAD: begin
                    own_reg   <= head_rd;
                    steal_reg <= '0;
                    state_reg <= head_rd.empty ? ST_STEAL_RD : ST_POP_RD;
                end
                ST_STEAL_RD: begin
                    if (steal_take) begin
                        victim_reg <= head_rd.idx;
                        state_reg  <= ST_STEAL_WB;
                    end else if (steal_last) begin
                        state_reg <= ST_POP_RD;
                    end else begin
                        steal_reg <= steal_reg + CPU_W'(1);
                    end
                end
                ST_STEAL_WB: begin
                    head_reg[head_sel] <= link_rd_data;
                    own_reg            <= '{empty: 1'b0, idx: victim_reg};
                    if (steal_last) begin
                        state_reg <= ST_POP_RD;
                    end else begin
                        steal_reg <= steal_reg + CPU_W'(1);
                        state_reg <= ST_STEAL_RD;
                    end
                end
                ST_POP_RD: begin
                    if (own_reg.empty) begin
                        res_reg.status        <= STATUS_EMPTY;
                        res_reg.alloc_address <= '0;
                        state_reg             <= ST_RESP;
                    end else begin
                        state_reg <= ST_POP_WB;
                    end
                end
                ST_POP_WB: begin
                    head_reg[head_sel]    <= link_rd_data;
                    res_reg.status        <= STATUS_OK;
                    res_reg.alloc_address <= pop_addr;
                    state_reg             <= ST_RESP;
                end
                ST_RESP: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP) && !func_reg ? 1'b1 : (state_reg == ST_RESP);
    assign res       = res_reg;

endmodule

// ===== rtl/core/per_cpu_page_allocator_top.sv =====
// A free writes the page's link and its list head. An allocate from a non-empty list
//   pops its head; one from an empty list first takes a page from each other non-empty
//   list in CPU order, and returns an empty status when no page is found anywhere.
// Throughput: one request at a time; the next is taken once this one's result is in
//   the output register, which lets the result wait while the next beat is accepted.
// The refill walk is set by the single read port of the link memory: one link a CPU.
// Reset (aresetn, synchronous): all lists empty, region registers to their defaults.
module per_cpu_page_allocator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [pca_pkg::CPU_IN_W-1:0]  s_cpu_index,
    input  logic [pca_pkg::ADDR_W-1:0]    s_page_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [pca_pkg::ADDR_W-1:0]    m_alloc_address,
    input  logic                          cfg_wr_en,
    input  logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pca_pkg::ADDR_W-1:0]    cfg_wdata
);
    import pca_pkg::*;

    cfg_t      cfg_reg;
    logic      m_valid_reg;
    result_t   m_beat_reg;

    logic      res_valid;
    logic      res_ready;
    result_t   res;
    link_req_t link_req;
    link_t     link_rd_data;

    // Region registers: the user must write them only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.region_start <= REGION_START_RST;
            cfg_reg.region_end   <= REGION_END_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_REGION_START) begin
                cfg_reg.region_start <= cfg_wdata;
            end else if (cfg_index == REG_REGION_END) begin
                cfg_reg.region_end <= cfg_wdata;
            end
        end
    end

    // Request sequencer and list heads
    pca_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_func      (s_func),
        .in_cpu       (cpu_wrap(s_cpu_index)),
        .in_addr      (s_page_address),
        .cfg          (cfg_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready),
        .link_req     (link_req),
        .link_rd_data (link_rd_data)
    );

    // Next-page links, one entry per page, read data registered
    logic [LINK_W-1:0] ram_rd_data;

    pca_link_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .aclk    (aclk),
        .rd_en   (link_req.rd_en),
        .rd_addr (link_req.rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (link_req.wr_en),
        .wr_addr (link_req.wr_addr),
        .wr_data (link_req.wr_data)
    );

    assign link_rd_data = link_t'(ram_rd_data);

    // Output register: load a new beat when the slot is empty or draining.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
                m_beat_reg  <= res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_beat_reg.status;
    assign m_alloc_address = m_beat_reg.alloc_address;

endmodule

// ===== rtl/core/pca_checker.sv =====
module pca_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_func,
    input logic [pca_pkg::CPU_IN_W-1:0]  s_cpu_index,
    input logic [pca_pkg::ADDR_W-1:0]    s_page_address,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic [pca_pkg::ADDR_W-1:0]    m_alloc_address,
    input logic                          cfg_wr_en,
    input logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [pca_pkg::ADDR_W-1:0]    cfg_wdata
);
    import pca_pkg::*;

    // A result beat stalled by the consumer holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_alloc_address))
        else $error("result beat changed while stalled");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_EMPTY
                     || m_status == STATUS_BAD_ADDR))
        else $error("undefined status code");

    // Any failed request carries a zero address.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_alloc_address == '0)
        else $error("failed request returned an address");

    // Reset drops any pending result.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind per_cpu_page_allocator_top pca_checker u_pca_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    import pca_pkg::*;

    // Request kinds on s_func
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [ADDR_W-1:0] PAGE_SIZE = ADDR_W'(PAGE_BYTES);

    // Settle margin after draining, well above the longest allocate (refill over all other lists).
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic                func;
        logic [CPU_IN_W-1:0] cpu_index;
        logic [ADDR_W-1:0]   page_address;
    } page_req_t;

    logic                 aclk;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_func          = FUNC_ALLOC;
    logic [CPU_IN_W-1:0]  s_cpu_index     = '0;
    logic [ADDR_W-1:0]    s_page_address  = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [1:0]           m_status;
    logic [ADDR_W-1:0]    m_alloc_address;
    logic                 cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = REG_REGION_START;
    logic [ADDR_W-1:0]    cfg_wdata       = '0;

    // Request beats waiting to be offered, and outcomes waiting to come back
    page_req_t request_queue[$];
    result_t   outcome_queue[$];
    page_req_t launch_req;

    // Shadow allocator: region registers, list heads and page links
    logic [ADDR_W-1:0] region_start_m = REGION_START_RST;
    logic [ADDR_W-1:0] region_end_m   = REGION_END_RST;
    link_t             free_heads[CPUS];
    link_t             page_links[NUM_PAGES];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fault_count    = 0;

    logic hold_start = 1'b0;
    int   hold_left  = 0;

    per_cpu_page_allocator_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_cpu_index     (s_cpu_index),
        .s_page_address  (s_page_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_alloc_address (m_alloc_address),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #800000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------

    // Addresses are rebuilt from the region start rounded down to a page.
    function automatic logic [ADDR_W-1:0] page_base();
        return region_start_m - (region_start_m % PAGE_SIZE);
    endfunction

    function automatic void push_page(int unsigned cpu, page_idx_t idx);
        page_links[idx] = free_heads[cpu];
        free_heads[cpu] = '{empty: 1'b0, idx: idx};
    endfunction

    function automatic link_t pop_page(int unsigned cpu);
        link_t head;
        head = free_heads[cpu];
        if (!head.empty) begin
            free_heads[cpu] = page_links[head.idx];
        end
        return head;
    endfunction

    // Apply one request to the shadow lists and return the result it must produce.
    function automatic result_t predict_outcome(logic func, logic [CPU_IN_W-1:0] cpu_raw,
                                                logic [ADDR_W-1:0] addr);
        result_t           res;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] pidx;
        int unsigned       cpu;
        link_t             taken;
        bit                bad;
        cpu  = int'(cpu_raw) % CPUS;
        base = page_base();
        res.status        = STATUS_OK;
        res.alloc_address = '0;
        if (func == FUNC_FREE) begin
            pidx = (addr - base) / PAGE_SIZE;
            bad  = (addr % PAGE_SIZE) != 0 || addr < region_start_m ||
                   addr >= region_end_m || pidx >= ADDR_W'(NUM_PAGES);
            if (bad) begin
                res.status = STATUS_BAD_ADDR;
            end else begin
                push_page(cpu, page_idx_t'(pidx));
            end
            return res;
        end
        // Empty own list: steal one page from each other CPU, in CPU order.
        if (free_heads[cpu].empty) begin
            for (int c = 0; c < CPUS; c++) begin
                if (c != cpu) begin
                    taken = pop_page(c);
                    if (!taken.empty) begin
                        push_page(cpu, taken.idx);
                    end
                end
            end
        end
        taken = pop_page(cpu);
        if (taken.empty) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.alloc_address = base + (ADDR_W'(taken.idx) << PAGE_SHIFT);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer queued beats, predict each one at acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Predict from the payload that was on the ports at this edge.
            if (s_valid && s_ready) begin
                outcome_queue.push_back(predict_outcome(s_func, s_cpu_index, s_page_address));
            end
            // Load the next beat only once the current one is gone; otherwise hold.
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    launch_req = request_queue.pop_front();
                    s_valid        <= 1'b1;
                    s_func         <= launch_req.func;
                    s_cpu_index    <= launch_req.cpu_index;
                    s_page_address <= launch_req.page_address;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the sender keeps running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare every accepted result beat with the oldest outcome
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_queue.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("%0t: result beat with no request outstanding: status %0d addr %h",
                                 $time, m_status, m_alloc_address);
                    end
                end else begin
                    want = outcome_queue.pop_front();
                    if (m_status !== want.status || m_alloc_address !== want.alloc_address) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT) begin
                            $display("%0t: expected status %0d addr %h, got status %0d addr %h",
                                     $time, want.status, want.alloc_address,
                                     m_status, m_alloc_address);
                        end
                    end
                end
            end
            // Stall at random, and hard while a hold-off is running.
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    task automatic queue_req(logic func, int unsigned cpu, logic [ADDR_W-1:0] addr);
        page_req_t req;
        req.func         = func;
        req.cpu_index    = CPU_IN_W'(cpu);
        req.page_address = addr;
        request_queue.push_back(req);
    endtask

    // Sample at the falling edge so that every update of this cycle has landed.
    task automatic wait_idle();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || outcome_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == REG_REGION_START) begin
            region_start_m = value;
        end else begin
            region_end_m = value;
        end
    endtask

    // Mostly well-formed frees inside the first span pages of the region and
    // allocates; the rest is junk addresses and addresses just off the edges.
    task automatic queue_random(int n, int free_pct, int span);
        int unsigned       roll;
        int unsigned       lo;
        logic [ADDR_W-1:0] addr;
        lo = (region_start_m % PAGE_SIZE != 0) ? 1 : 0;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                addr = $urandom();
                queue_req(FUNC_FREE, $urandom_range(7), addr);
            end else if (roll < 12) begin
                case ($urandom_range(2))
                    0:       addr = region_end_m;
                    1:       addr = region_start_m - PAGE_SIZE;
                    default: addr = page_base() + ADDR_W'(NUM_PAGES) * PAGE_SIZE;
                endcase
                queue_req(FUNC_FREE, $urandom_range(7), addr);
            end else if (roll < free_pct) begin
                addr = page_base() + ADDR_W'(lo + $urandom_range(span - 1)) * PAGE_SIZE;
                queue_req(FUNC_FREE, $urandom_range(7), addr);
            end else begin
                queue_req(FUNC_ALLOC, $urandom_range(7), $urandom());
            end
        end
    endtask

    // Drain, reprogram the region, set the idle and stall mix and queue a random batch.
    task automatic run_phase(logic [ADDR_W-1:0] start_addr, logic [ADDR_W-1:0] end_addr,
                             int idle_pct, int stall_pct, int n, int free_pct, int span);
        wait_idle();
        write_reg(REG_REGION_START, start_addr);
        write_reg(REG_REGION_END, end_addr);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        queue_random(n, free_pct, span);
    endtask

    // Queue a burst and block the receiver for a long stretch so the block backs up.
    task automatic back_up_results(int n, int free_pct, int span);
        wait_idle();
        send_idle_pct <= 0;
        queue_random(n, free_pct, span);
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
    endtask

    initial begin
        for (int c = 0; c < CPUS; c++) begin
            free_heads[c] = LINK_NULL;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default region 8000_0000 .. 8800_0000, no idling.
        queue_req(FUNC_ALLOC, 0, 32'h0);            // every list empty
        queue_req(FUNC_ALLOC, 7, 32'hFFFF_FFFF);    // every list empty
        queue_req(FUNC_FREE,  0, 32'h8000_0000);    // lowest page
        queue_req(FUNC_FREE,  7, 32'h87FF_F000);    // highest page
        queue_req(FUNC_FREE,  1, 32'h7FFF_F000);    // below region
        queue_req(FUNC_FREE,  1, 32'h8800_0000);    // at region end
        queue_req(FUNC_FREE,  1, 32'h8000_0FFF);    // misaligned
        queue_req(FUNC_FREE,  6, 32'hFFFF_FFFF);
        queue_req(FUNC_FREE,  6, 32'h0000_0000);
        queue_req(FUNC_FREE,  2, 32'h8123_4000);
        queue_req(FUNC_FREE,  2, 32'h8123_4000);    // double free: self loop
        queue_req(FUNC_FREE,  3, 32'h8000_1000);
        queue_req(FUNC_ALLOC, 4, 32'h0);            // refill from the other lists
        queue_req(FUNC_ALLOC, 4, 32'h0);
        queue_req(FUNC_ALLOC, 4, 32'h0);
        queue_req(FUNC_ALLOC, 4, 32'h0);
        queue_req(FUNC_ALLOC, 2, 32'h0);            // walks the looped list
        queue_req(FUNC_ALLOC, 0, 32'h0);
        queue_req(FUNC_ALLOC, 5, 32'h0);
        queue_req(FUNC_FREE,  5, 32'h8000_2000);
        queue_req(FUNC_ALLOC, 5, 32'h0);            // plain pop

        // Random phases; lists carry over, so old pages follow each new base.
        run_phase(REGION_START_RST, REGION_END_RST, 0, 0, 70, 55, NUM_PAGES);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 58, 0, 70, 55, 4096);
        run_phase(32'h1234_5678, 32'h2000_0000, 0, 58, 70, 55, 2048);
        back_up_results(24, 55, 2048);
        run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 33, 33, 50, 50, 1);
        run_phase(32'h4000_0000, 32'h0000_0000, 0, 0, 30, 50, 64);
        run_phase(REGION_START_RST, REGION_END_RST, 33, 33, 90, 60, 16);
        back_up_results(24, 60, 16);

        wait_idle();
        if (fault_count == 0 && outcome_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
